// ===== sv/tsc_pkg.sv =====
// Shared types and constants for the two-stack cursor list.
package tsc_pkg;

  // Default geometry
  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_ELEM_WIDTH  = 32;

  // Fixed port widths
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 10;

  typedef enum logic [2:0] {
    MODE_PUT_BEFORE = 3'd0,
    MODE_PUT_AFTER  = 3'd1,
    MODE_GET_BEFORE = 3'd2,
    MODE_GET_AFTER  = 3'd3,
    MODE_MOVE_LEFT  = 3'd4,
    MODE_MOVE_RIGHT = 3'd5,
    MODE_TO_BEGIN   = 3'd6,
    MODE_TO_END     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BEGIN = 2'd2,
    ST_END   = 2'd3
  } status_t;

endpackage

// ===== sv/tsc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
module tsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/two_stack_cursor_list_core.sv =====
// Top level of the two-stack cursor list: control sequencer and the two stack RAMs.
//
// Usage:
//  - Request channel: drive mode/value and raise start; the request is taken on a
//    clock edge where start is high and busy is low.
//  - Result channel: done pulses for exactly one cycle with data, status, count
//    and has_current valid. The receiver cannot stall; it must take the result.
//  - Sequencing:
//      put, walk with an empty source, failure or lone-element get: result
//      in the cycle after the request, busy stays low (one request per cycle).
//      get and single move: one stack RAM read, registered, with busy high.
//      walk to begin/end: steps over the elements in the read-modify-write
//      loop over the two stack RAMs, with busy high until it stops.
//  - Elements left of the cursor live in the before RAM, right of it in the
//    after RAM; the top of each stack is the element nearest the cursor.
//  - A step writes one RAM and reads the other, so no entry is read and
//    written in the same cycle and no forwarding is needed.
//  - Reset (synchronous, active high) empties the list at once; the RAM
//    contents are not cleared, only the depth counters and the cursor.
module two_stack_cursor_list_core
  import tsc_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [DATA_W-1:0]  value,
  output logic               done,
  output logic [DATA_W-1:0]  data,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count,
  output logic               has_current
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = DW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_STEP
  } state_t;

  // Control and payload registers
  state_t                state, state_next;
  logic                  dir_left, dir_left_next;   // source stack is the before stack
  logic                  walk, walk_next;
  logic [DW-1:0]         bdepth, bdepth_next;
  logic [DW-1:0]         adepth, adepth_next;
  logic [ELEM_WIDTH-1:0] cur_val, cur_val_next;
  logic                  cur_valid, cur_valid_next;
  logic                  done_next;
  logic [DATA_W-1:0]     data_next;
  status_t               status_q, status_next;

  // RAM ports
  logic                  b_we, a_we;
  logic [ELEM_WIDTH-1:0] b_wdata, a_wdata;
  logic [ELEM_WIDTH-1:0] b_rdata, a_rdata;

  // Decode helpers
  logic                  accept;
  mode_t                 mode_in;
  logic                  left;
  logic [DW-1:0]         src_d, dst_d;
  logic                  src_empty, src_full, dst_full;
  logic [ELEM_WIDTH-1:0] vin;
  logic [ELEM_WIDTH-1:0] src_rdata;
  logic                  do_step;
  logic [ELEM_WIDTH-1:0] step_wdata;
  logic                  do_push;
  logic                  do_pop;
  logic [CW-1:0]         total;

  assign accept  = start && (state == S_IDLE);
  assign mode_in = mode_t'(mode);
  assign vin     = ELEM_WIDTH'(value);

  // In idle the direction comes from the request (before stack / leftward on
  // even modes), otherwise from the latched direction.
  assign left      = (state == S_IDLE) ? ~mode[0] : dir_left;
  assign src_d     = left ? bdepth : adepth;
  assign dst_d     = left ? adepth : bdepth;
  assign src_empty = (src_d == '0);
  assign src_full  = (src_d >= DW'(STACK_DEPTH));
  assign dst_full  = (dst_d >= DW'(STACK_DEPTH));
  assign src_rdata = dir_left ? b_rdata : a_rdata;

  always_comb begin
    state_next     = state;
    dir_left_next  = dir_left;
    walk_next      = walk;
    bdepth_next    = bdepth;
    adepth_next    = adepth;
    cur_val_next   = cur_val;
    cur_valid_next = cur_valid;
    done_next      = 1'b0;
    data_next      = '0;
    status_next    = status_q;
    do_step        = 1'b0;
    step_wdata     = cur_val;
    do_push        = 1'b0;
    do_pop         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          dir_left_next = left;
          unique case (mode_in)
            MODE_PUT_BEFORE, MODE_PUT_AFTER: begin
              done_next   = 1'b1;
              status_next = ST_OK;
              if (!cur_valid) begin
                cur_val_next   = vin;
                cur_valid_next = 1'b1;
              end else if (src_full) begin
                status_next = ST_FULL;
              end else begin
                do_push = 1'b1;
              end
            end
            MODE_GET_BEFORE, MODE_GET_AFTER: begin
              if (cur_valid && bdepth == '0 && adepth == '0) begin
                // lone element: hand back the cursor itself
                done_next      = 1'b1;
                status_next    = ST_OK;
                data_next      = DATA_W'(cur_val);
                cur_valid_next = 1'b0;
                cur_val_next   = '0;
              end else if (!cur_valid || src_empty) begin
                done_next   = 1'b1;
                status_next = left ? ST_BEGIN : ST_END;
              end else begin
                do_pop     = 1'b1;
                state_next = S_GET;
              end
            end
            MODE_MOVE_LEFT, MODE_MOVE_RIGHT: begin
              if (!cur_valid || src_empty) begin
                done_next   = 1'b1;
                status_next = left ? ST_BEGIN : ST_END;
              end else if (dst_full) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else begin
                do_step    = 1'b1;
                walk_next  = 1'b0;
                state_next = S_STEP;
              end
            end
            MODE_TO_BEGIN, MODE_TO_END: begin
              if (!cur_valid || src_empty) begin
                done_next   = 1'b1;
                status_next = ST_OK;
              end else if (dst_full) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else begin
                do_step    = 1'b1;
                walk_next  = 1'b1;
                state_next = S_STEP;
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_GET: begin
        done_next   = 1'b1;
        status_next = ST_OK;
        data_next   = DATA_W'(src_rdata);
        state_next  = S_IDLE;
      end
      S_STEP: begin
        // the element read last cycle becomes the cursor
        cur_val_next = src_rdata;
        if (walk && !src_empty && !dst_full) begin
          do_step    = 1'b1;
          step_wdata = src_rdata;
        end else begin
          done_next   = 1'b1;
          status_next = (walk && !src_empty) ? ST_FULL : ST_OK;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // depth bookkeeping
    if (do_push) begin
      if (left) begin
        bdepth_next = bdepth + DW'(1);
      end else begin
        adepth_next = adepth + DW'(1);
      end
    end
    if (do_pop) begin
      if (left) begin
        bdepth_next = bdepth - DW'(1);
      end else begin
        adepth_next = adepth - DW'(1);
      end
    end
    if (do_step) begin
      if (left) begin
        bdepth_next = bdepth - DW'(1);
        adepth_next = adepth + DW'(1);
      end else begin
        adepth_next = adepth - DW'(1);
        bdepth_next = bdepth + DW'(1);
      end
    end
  end

  // RAM write side: push writes the value into its own stack, a step writes
  // the outgoing cursor into the destination stack.
  always_comb begin
    b_we    = 1'b0;
    a_we    = 1'b0;
    b_wdata = vin;
    a_wdata = vin;
    if (do_push) begin
      b_we = left;
      a_we = !left;
    end else if (do_step) begin
      b_we    = !left;
      a_we    = left;
      b_wdata = step_wdata;
      a_wdata = step_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dir_left  <= 1'b0;
      walk      <= 1'b0;
      bdepth    <= '0;
      adepth    <= '0;
      cur_val   <= '0;
      cur_valid <= 1'b0;
      done      <= 1'b0;
      data      <= '0;
      status_q  <= ST_OK;
    end else begin
      state     <= state_next;
      dir_left  <= dir_left_next;
      walk      <= walk_next;
      bdepth    <= bdepth_next;
      adepth    <= adepth_next;
      cur_val   <= cur_val_next;
      cur_valid <= cur_valid_next;
      done      <= done_next;
      data      <= data_next;
      status_q  <= status_next;
    end
  end

  // Stack RAMs: write at the depth (next free slot), read at depth-1 (top)
  tsc_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_before_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (AW'(bdepth)),
    .wdata (b_wdata),
    .raddr (AW'(bdepth - DW'(1))),
    .rdata (b_rdata)
  );

  tsc_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_after_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(adepth)),
    .wdata (a_wdata),
    .raddr (AW'(adepth - DW'(1))),
    .rdata (a_rdata)
  );

  assign busy        = (state != S_IDLE);
  assign status      = status_q;
  assign total       = CW'(bdepth) + CW'(adepth) + CW'(cur_valid);
  assign count       = COUNT_W'(total);
  assign has_current = cur_valid;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (bdepth <= DW'(STACK_DEPTH)) && (adepth <= DW'(STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> (bdepth == '0 && adepth == '0))
    else $error("stack holds elements without a cursor");

  a_get_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_GET) |=> (done && state == S_IDLE))
    else $error("get result not delivered after RAM read");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status_q != ST_OK) |-> (data == '0))
    else $error("failed request returned data");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for two_stack_cursor_list_core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_top
  import tsc_pkg::*;
();

  localparam int DEPTH = DEF_STACK_DEPTH;
  // Cycles with no request taken and no result seen before giving up.
  localparam int LIMIT = 4000;
  // Quiet time after the last result, covering the longest walk.
  localparam int TAIL_CYCLES = 600;
  localparam int REQ_TOTAL = 1950;

  // Stimulus mixes for the random part
  typedef enum int {MIX_FILL, MIX_EMPTY, MIX_MOVE, MIX_NOISE} mix_t;

  // One pending request; hold marks a pause until all results are in
  typedef struct {
    mode_t       mode;
    logic [31:0] value;
    int          gap;
    bit          hold;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               has_current;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         mode = '0;
  logic [DATA_W-1:0]  value = '0;
  logic               busy;
  logic               done;
  logic [DATA_W-1:0]  data;
  logic [1:0]         status;
  logic [COUNT_W-1:0] count;
  logic               has_current;

  req_t     pend_q[$];
  outcome_t want_q[$];
  int       err_n = 0;
  int       stall_n = 0;
  int       idle_left = 0;
  bit       calm = 0;

  // Predicted list state: left stack, right stack, cursor
  logic [DATA_W-1:0] left_mem [DEPTH];
  logic [DATA_W-1:0] right_mem [DEPTH];
  int                left_n = 0;
  int                right_n = 0;
  logic [DATA_W-1:0] cur_val = '0;
  bit                cur_ok = 0;

  two_stack_cursor_list_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .value(value),
    .done(done), .data(data), .status(status), .count(count), .has_current(has_current)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Step the cursor one place; the cursor goes onto the opposite stack.
  function automatic status_t shift_one(bit to_left);
    if (to_left) begin
      if (!cur_ok || left_n == 0) return ST_BEGIN;
      if (right_n >= DEPTH) return ST_FULL;
      right_mem[right_n] = cur_val;
      right_n++;
      left_n--;
      cur_val = left_mem[left_n];
    end else begin
      if (!cur_ok || right_n == 0) return ST_END;
      if (left_n >= DEPTH) return ST_FULL;
      left_mem[left_n] = cur_val;
      left_n++;
      right_n--;
      cur_val = right_mem[right_n];
    end
    return ST_OK;
  endfunction

  // Apply one request to the predicted list and form its result.
  function automatic void list_apply(mode_t m, logic [DATA_W-1:0] v, output outcome_t o);
    status_t st;
    logic [DATA_W-1:0] got;
    bit to_left;
    got = '0;
    st = ST_OK;
    case (m)
      MODE_PUT_BEFORE, MODE_PUT_AFTER: begin
        if (!cur_ok) begin
          // empty list: the value becomes the cursor
          cur_val = v;
          cur_ok = 1;
        end else if (m == MODE_PUT_BEFORE) begin
          if (left_n >= DEPTH) st = ST_FULL;
          else begin
            left_mem[left_n] = v;
            left_n++;
          end
        end else begin
          if (right_n >= DEPTH) st = ST_FULL;
          else begin
            right_mem[right_n] = v;
            right_n++;
          end
        end
      end
      MODE_GET_BEFORE, MODE_GET_AFTER: begin
        if (cur_ok && left_n == 0 && right_n == 0) begin
          // cursor is the only element: hand it out, list goes empty
          got = cur_val;
          cur_ok = 0;
          cur_val = '0;
        end else if (m == MODE_GET_BEFORE) begin
          if (!cur_ok || left_n == 0) st = ST_BEGIN;
          else begin
            left_n--;
            got = left_mem[left_n];
          end
        end else begin
          if (!cur_ok || right_n == 0) st = ST_END;
          else begin
            right_n--;
            got = right_mem[right_n];
          end
        end
      end
      MODE_MOVE_LEFT:  st = shift_one(1);
      MODE_MOVE_RIGHT: st = shift_one(0);
      default: begin
        // walk: step until the source side is empty or the far side fills
        to_left = (m == MODE_TO_BEGIN);
        while (cur_ok && (to_left ? left_n : right_n) != 0 && st == ST_OK) begin
          if (shift_one(to_left) != ST_OK) st = ST_FULL;
        end
      end
    endcase
    o.data = got;
    o.status = st;
    o.count = COUNT_W'(left_n + right_n + (cur_ok ? 1 : 0));
    o.has_current = cur_ok;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_req(mode_t m, logic [31:0] v);
    req_t r;
    r.mode = m;
    r.value = v;
    r.gap = calm ? 0 : $urandom_range(0, 19);
    r.hold = 0;
    pend_q.push_back(r);
  endtask

  task automatic queue_hold();
    req_t r;
    r.mode = MODE_PUT_BEFORE;
    r.value = '0;
    r.gap = 0;
    r.hold = 1;
    pend_q.push_back(r);
  endtask

  function automatic mode_t pick_mode(mix_t mix);
    int r;
    r = $urandom_range(0, 9);
    case (mix)
      MIX_FILL:  if (r < 8) return mode_t'($urandom_range(0, 1));
      MIX_EMPTY: if (r < 8) return mode_t'($urandom_range(2, 3));
      MIX_MOVE: begin
        if (r < 6) return mode_t'($urandom_range(4, 5));
        if (r < 8) return mode_t'($urandom_range(6, 7));
      end
      default: ;
    endcase
    return mode_t'($urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one request at a time, with a random wait after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t o;
    req_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        list_apply(mode_t'(mode), value, o);
        want_q.push_back(o);
      end
      // request slot is free unless one is still waiting on busy
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pend_q.size() == 0) begin
          start <= 1'b0;
        end else if (pend_q[0].hold) begin
          start <= 1'b0;
          if (want_q.size() == 0) void'(pend_q.pop_front());
        end else begin
          r = pend_q.pop_front();
          mode <= r.mode;
          value <= r.value;
          start <= 1'b1;
          idle_left = r.gap;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done pulse is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        $display("%0t: result with none pending: data %h status %0d count %0d cur %0b",
                 $time, data, status, count, has_current);
        err_n++;
      end else begin
        w = want_q.pop_front();
        if (data !== w.data) begin
          $display("%0t: data mismatch: expected %h actual %h", $time, w.data, data);
          err_n++;
        end
        if (status !== w.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, w.status, status);
          err_n++;
        end
        if (count !== w.count) begin
          $display("%0t: count mismatch: expected %0d actual %0d", $time, w.count, count);
          err_n++;
        end
        if (has_current !== w.has_current) begin
          $display("%0t: has_current mismatch: expected %0b actual %0b",
                   $time, w.has_current, has_current);
          err_n++;
        end
      end
    end
  end

  // Watchdog: cycles with neither a request taken nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_n <= 0;
    else stall_n <= stall_n + 1;
    if (stall_n >= LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    mix_t mix;
    int   len;

    // Directed: empty-list cases, lone element, boundaries, walks
    queue_req(MODE_GET_BEFORE, '0);
    queue_req(MODE_GET_AFTER, '1);
    queue_req(MODE_MOVE_LEFT, '0);
    queue_req(MODE_MOVE_RIGHT, '1);
    queue_req(MODE_TO_BEGIN, '0);
    queue_req(MODE_TO_END, '1);
    queue_req(MODE_PUT_BEFORE, '0);         // becomes the cursor
    queue_req(MODE_GET_BEFORE, '1);         // lone element comes back
    queue_req(MODE_PUT_AFTER, '1);
    queue_req(MODE_GET_AFTER, '0);          // lone element via the other side
    queue_req(MODE_PUT_AFTER, 32'h8000_0001);
    queue_req(MODE_PUT_BEFORE, 32'h7fff_fffe);
    queue_req(MODE_PUT_AFTER, 32'hffff_ffff);
    queue_req(MODE_PUT_AFTER, 32'h0000_0000);
    queue_req(MODE_MOVE_LEFT, '0);
    queue_req(MODE_MOVE_LEFT, '0);          // nothing left of cursor
    queue_req(MODE_MOVE_RIGHT, '0);
    queue_req(MODE_MOVE_RIGHT, '0);
    queue_req(MODE_MOVE_RIGHT, '0);
    queue_req(MODE_MOVE_RIGHT, '0);         // nothing right of cursor
    queue_req(MODE_TO_BEGIN, '0);
    queue_req(MODE_GET_BEFORE, '0);         // at beginning, list not empty
    queue_req(MODE_GET_AFTER, '0);
    queue_req(MODE_TO_END, '0);
    queue_req(MODE_GET_AFTER, '0);          // at end, list not empty
    queue_hold();

    // Pack both stacks: full pushes, walks and moves that stop on a full side
    calm = 1;
    repeat (262) queue_req(MODE_PUT_BEFORE, $urandom());
    calm = 0;
    repeat (110) queue_req(MODE_PUT_AFTER, $urandom());
    queue_req(MODE_TO_BEGIN, $urandom());   // right side fills, walk stops part way
    repeat (3) queue_req(MODE_MOVE_LEFT, $urandom());
    repeat (3) queue_req(MODE_GET_AFTER, $urandom());
    repeat (3) queue_req(MODE_MOVE_LEFT, $urandom());
    repeat (6) queue_req(MODE_PUT_AFTER, $urandom());
    queue_req(MODE_TO_END, $urandom());     // left side fills, walk stops part way
    repeat (3) queue_req(MODE_MOVE_RIGHT, $urandom());
    repeat (3) queue_req(MODE_PUT_BEFORE, $urandom());
    queue_hold();

    // Random episodes of biased traffic
    while (pend_q.size() < REQ_TOTAL) begin
      mix = mix_t'($urandom_range(0, 3));
      len = $urandom_range(20, 160);
      calm = ($urandom_range(0, 3) == 0);
      repeat (len) queue_req(pick_mode(mix), $urandom());
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || start || want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_n == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tsc_pkg.sv
sv/tsc_ram.sv
sv/two_stack_cursor_list_core.sv
tb/tb_top.sv
